@@ rtl/core/byte_stream_hash_32_assert.svh @@
// Assertion macros shared by the hash core. They rely on clk_i and rst_ni being in scope.
`ifndef BYTE_STREAM_HASH_32_ASSERT_SVH
`define BYTE_STREAM_HASH_32_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bsh_pkg.sv @@
package bsh_pkg;

  localparam int unsigned NUM_LANES  = 8;
  localparam int unsigned BLK_BYTES  = 32;
  localparam int unsigned BLK_W      = 8 * BLK_BYTES;
  localparam int unsigned TAIL_W     = 64;
  localparam int unsigned LEN_W      = 64;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic [31:0] word_t;

  localparam word_t MIX_INIT = 32'd1111111111;
  localparam word_t OFF_INIT = 32'd111111111;

  localparam word_t LANE_INIT [NUM_LANES] = '{
    32'd1, 32'd11, 32'd111, 32'd1111, 32'd11111, 32'd111111, 32'd1111111, 32'd11111111
  };

  localparam logic [4:0] ROUND_ROT [NUM_LANES] = '{
    5'd8, 5'd23, 5'd10, 5'd21, 5'd12, 5'd19, 5'd14, 5'd17
  };

  // One command for the back end: a block round, a finalisation, or both.
  typedef struct packed {
    logic             round;
    logic             fin;
    logic [4:0]       rem;
    logic             ge8;
    logic             gt12;
    logic             ge32;
    word_t            n32;
    logic [BLK_W-1:0] blk;
    logic [TAIL_W-1:0] tail;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_RUN,
    ST_F16,
    ST_F8,
    ST_TAIL,
    ST_TAILB,
    ST_MIXA,
    ST_MIX1,
    ST_MIX2,
    ST_MIX3,
    ST_MIX4,
    ST_MIX5,
    ST_MIX6,
    ST_DONE
  } back_state_e;

  function automatic word_t rotl32(word_t x, logic [4:0] s);
    return (x << s) | (x >> (6'd32 - {1'b0, s}));
  endfunction

  // Little-endian word at word index wi of a 32-byte block.
  function automatic word_t word_at(logic [BLK_W-1:0] v, logic [2:0] wi);
    return v[{wi, 5'b00000} +: 32];
  endfunction

  // Keeps the lowest n bytes of a word.
  function automatic word_t byte_mask(logic [1:0] n);
    word_t m;
    case (n)
      2'd0:    m = 32'h0000_0000;
      2'd1:    m = 32'h0000_00ff;
      2'd2:    m = 32'h0000_ffff;
      2'd3:    m = 32'h00ff_ffff;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/bsh_front.sv @@
module bsh_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [63:0]   data_i,
  input  logic [3:0]    byte_count_i,
  input  logic          last_i,
  input  logic          full_i,
  output logic          push_o,
  output bsh_pkg::cmd_t cmd_o
);
  import bsh_pkg::*;

  logic [4:0]       fill_q, fill_d;
  logic [LEN_W-1:0] len_q, len_d, len_new;
  logic [BLK_W-1:0] buf_q, buf_d, blk;
  logic [3:0]       cnt;
  logic [5:0]       fill_sum;
  logic [4:0]       offs;
  logic             wr;
  logic [7:0]       dbyte;
  logic             accept, round;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cnt      = (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;
    fill_sum = {1'b0, fill_q} + {2'b00, cnt};
    round    = fill_sum[5];
    len_new  = len_q + {{(LEN_W-4){1'b0}}, cnt};
    offs     = '0;
    wr       = 1'b0;
    dbyte    = '0;
    // Each buffer byte picks the input byte that lands on it, if any. Bytes that wrap
    // past the end of the block go only into the running buffer, not into the round block.
    for (int j = 0; j < BLK_BYTES; j++) begin
      offs  = 5'(j) - fill_q;
      wr    = ({1'b0, offs} < {2'b00, cnt});
      dbyte = data_i[{offs[2:0], 3'b000} +: 8];
      buf_d[8*j +: 8] = wr ? dbyte : buf_q[8*j +: 8];
      blk[8*j +: 8]   = (wr && (5'(j) >= fill_q)) ? dbyte : buf_q[8*j +: 8];
    end
  end

  always_comb begin
    push_o     = accept && (round || last_i);
    cmd_o.round = round;
    cmd_o.fin   = last_i;
    cmd_o.rem   = fill_sum[4:0];
    cmd_o.ge8   = |len_new[LEN_W-1:3];
    cmd_o.gt12  = (len_new > 64'd12);
    cmd_o.ge32  = |len_new[LEN_W-1:5];
    cmd_o.n32   = len_new[31:0];
    cmd_o.blk   = round ? blk : buf_d;
    cmd_o.tail  = buf_d[TAIL_W-1:0];

    fill_d = fill_q;
    len_d  = len_q;
    if (accept) begin
      if (last_i) begin
        fill_d = '0;
        len_d  = '0;
      end else begin
        fill_d = fill_sum[4:0];
        len_d  = len_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      len_q  <= '0;
    end else begin
      fill_q <= fill_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q <= buf_d;
    end
  end

endmodule

@@ rtl/core/bsh_fifo.sv @@
`include "byte_stream_hash_32_assert.svh"

module bsh_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bsh_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bsh_pkg::cmd_t data_o
);
  import bsh_pkg::*;

  cmd_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `BSH_ASSERT_IMP(a_no_pop_when_empty, pop_i, count_q != '0, "pop from empty queue")
  `BSH_ASSERT_IMP(a_no_push_when_full, push_i, !full_o, "push into full queue")

endmodule

@@ rtl/core/bsh_back.sv @@
`include "byte_stream_hash_32_assert.svh"

module bsh_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  bsh_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   hash_o
);
  import bsh_pkg::*;

  back_state_e      state_q, state_d;
  word_t            lane_q [NUM_LANES];
  word_t            lane_d [NUM_LANES];
  word_t            lane_rnd [NUM_LANES];
  word_t            mix_q, mix_d, off_q, off_d;
  word_t            hash_q, hash_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;
  logic             hash_load, hash_shown;
  word_t            sum8, mix_rnd;
  word_t            bx, cx, ex, fx, gx;
  logic [BLK_W-1:0] src;
  logic [2:0]       wi16, wi8;
  logic [2:0]       rt;

  // Leftover bytes sit in the tail field when the same item also completed a block.
  assign src  = cmd_i.round ? {{(BLK_W-TAIL_W){1'b0}}, cmd_i.tail} : cmd_i.blk;
  assign wi16 = {cmd_i.rem[4], 2'b00};
  assign wi8  = {cmd_i.rem[4], cmd_i.rem[3], 1'b0};
  assign rt   = cmd_i.rem[2:0];

  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign hash_o      = hash_q;

  assign bx = lane_q[1] ^ off_q;
  assign cx = lane_q[2] ^ mix_q;
  assign ex = lane_q[4] ^ off_q;
  assign fx = lane_q[5] ^ (rotl32(lane_q[4], 5'd18) + mix_q);
  assign gx = lane_q[6] ^ off_q;

  always_comb begin
    sum8 = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      sum8 = sum8 + lane_q[k];
    end
    mix_rnd = mix_q + sum8;
    for (int k = 0; k < NUM_LANES; k++) begin
      lane_rnd[k] = lane_q[k] + word_at(cmd_i.blk, 3'(NUM_LANES - 1 - k))
                    + rotl32(lane_q[k], ROUND_ROT[k]);
    end
    lane_rnd[0] = lane_rnd[0] + mix_rnd;
  end

  always_comb begin
    state_d     = state_q;
    lane_d      = lane_q;
    mix_d       = mix_q;
    off_d       = off_q;
    hash_d      = hash_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;

    case (state_q)
      ST_RUN: begin
        if (valid_i) begin
          if (cmd_i.round) begin
            lane_d = lane_rnd;
            mix_d  = mix_rnd;
          end
          if (cmd_i.fin) begin
            state_d = ST_F16;
          end else begin
            pop_o = 1'b1;
          end
        end
      end
      ST_F16: begin
        if (cmd_i.ge32) begin
          off_d = off_q + sum8;
        end
        if (cmd_i.rem[4]) begin
          for (int k = 0; k < 4; k++) begin
            lane_d[k] = lane_q[k] + word_at(src, 3'(k)) + rotl32(lane_q[k], ROUND_ROT[k]);
          end
        end
        state_d = ST_F8;
      end
      ST_F8: begin
        if (cmd_i.rem[4]) begin
          mix_d = mix_q + lane_q[0] + lane_q[1] + lane_q[2] + lane_q[3];
        end
        if (cmd_i.rem[3]) begin
          lane_d[0] = lane_q[0] + word_at(src, wi16) + rotl32(lane_q[0], 5'd8);
          lane_d[1] = lane_q[1] + word_at(src, wi16 | 3'd1) + rotl32(lane_q[1], 5'd23);
        end
        state_d = ST_TAIL;
      end
      ST_TAIL: begin
        mix_d = mix_q + (cmd_i.rem[3] ? lane_q[0] + lane_q[1] : '0)
                + ((rt != 3'd0) ? rotl32(lane_q[0], 5'd8) : '0);
        if (rt[2]) begin
          lane_d[0] = lane_q[0] + word_at(src, wi8) + rotl32(lane_q[0], 5'd23);
        end else begin
          lane_d[0] = lane_q[0] ^ (word_at(src, wi8) & byte_mask(rt[1:0]));
        end
        state_d = ST_TAILB;
      end
      ST_TAILB: begin
        // Five to seven leftover bytes: the bytes past the last whole word go into b.
        if (rt[2] && (rt[1:0] != 2'd0)) begin
          off_d     = off_q + lane_q[0] + lane_q[1];
          lane_d[1] = lane_q[1] + (word_at(src, wi8 | 3'd1) & byte_mask(rt[1:0]));
        end
        state_d = ST_MIXA;
      end
      ST_MIXA: begin
        lane_d[0] = lane_q[0] + lane_q[1] + off_q;
        state_d   = ST_MIX1;
      end
      ST_MIX1: begin
        mix_d = mix_q + rotl32(lane_q[0], 5'd8)
                + (cmd_i.gt12 ? rotl32(lane_q[2], 5'd22) + rotl32(lane_q[3], 5'd11) : '0)
                + (cmd_i.ge32 ? rotl32(lane_q[7], 5'd15) : '0);
        if (cmd_i.ge32) begin
          off_d = off_q + (rotl32(lane_q[4], 5'd20) ^ rotl32(lane_q[6], 5'd18));
        end
        state_d = ST_MIX2;
      end
      ST_MIX2: begin
        off_d   = off_q + mix_q + cmd_i.n32;
        mix_d   = mix_q + (rotl32(lane_q[0], 5'd13) ^ lane_q[7]);
        state_d = ST_MIX3;
      end
      ST_MIX3: begin
        lane_d[1] = bx;
        off_d     = off_q + (lane_q[0] ^ rotl32(bx, 5'd18));
        state_d   = ST_MIX4;
      end
      ST_MIX4: begin
        if (cmd_i.ge8) begin
          lane_d[2] = cx;
          mix_d     = mix_q + (lane_q[1] ^ rotl32(cx, 5'd15));
          lane_d[4] = ex;
          off_d     = off_q + (lane_q[3] ^ rotl32(ex, 5'd18));
        end
        state_d = ST_MIX5;
      end
      ST_MIX5: begin
        if (cmd_i.ge32) begin
          lane_d[5] = fx;
          off_d     = off_q + (lane_q[4] ^ rotl32(fx, 5'd19));
        end
        state_d = ST_MIX6;
      end
      ST_MIX6: begin
        if (cmd_i.ge32) begin
          lane_d[6] = gx;
          mix_d     = mix_q + (lane_q[5] ^ rotl32(gx, 5'd21));
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          hash_d      = mix_q + off_q;
          out_valid_d = 1'b1;
          lane_d      = LANE_INIT;
          mix_d       = MIX_INIT;
          off_d       = OFF_INIT;
          pop_o       = 1'b1;
          state_d     = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      lane_q      <= LANE_INIT;
      mix_q       <= MIX_INIT;
      off_q       <= OFF_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lane_q      <= lane_d;
      mix_q       <= mix_d;
      off_q       <= off_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
  end

  assign hash_load  = (state_q == ST_DONE) && slot_free;
  assign hash_shown = out_valid_q && (state_q == ST_RUN);

  `BSH_ASSERT_IMP(a_fin_holds_cmd, state_q != ST_RUN, valid_i, "finalisation lost its command")
  `BSH_ASSERT_NXT(a_hash_loaded, hash_load, hash_shown, "hash not presented after finalisation")

endmodule

@@ rtl/core/byte_stream_hash_32.sv @@
// 32-bit non-cryptographic hash of a byte message streamed in as items of up to eight bytes,
// with last marking the final item; one hash transaction follows each last item. The front end
// takes one item per clock while the two-entry command queue has room: it gathers bytes into a
// 32-byte block and issues a command for each completed block and for each message end. The
// back end applies each block round as it pops the block's command, so long messages stream at
// eight bytes per cycle while it is not finalising. Finalisation is a sequence of twelve steps in
// the back end, from ST_F16 through ST_MIX6 to ST_DONE, where the hash is loaded into the output
// register once the output slot is free and the next command is popped. in_ready_o falls while
// the queue is full behind a finalisation or behind a hash that the consumer has not yet taken.
module byte_stream_hash_32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] hash_o
);
  import bsh_pkg::*;

  cmd_t front_cmd, queue_cmd;
  logic push, full, pop, queue_valid;

  bsh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_i       (data_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  bsh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .data_o  (queue_cmd)
  );

  bsh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (queue_valid),
    .cmd_i       (queue_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hash_o      (hash_o)
  );

endmodule
